// ===== src/pfle_pkg.sv =====
`timescale 1ns / 1ps
// Package for the prime field power block: widths, register indexes, microcode
// types and the microcode program. Used by every other file; depends on nothing.
package pfle_pkg;

   localparam int MOD_BITS   = 12;
   localparam int EXP_BITS   = 32;
   localparam int PROD_BITS  = 2 * MOD_BITS;
   localparam int DVD_BITS   = (EXP_BITS > PROD_BITS) ? EXP_BITS : PROD_BITS;
   localparam int CNT_BITS   = $clog2(DVD_BITS);
   localparam int LOG_DEPTH  = 1 << MOD_BITS;
   localparam int ANTI_AW    = MOD_BITS + 1;
   localparam int ANTI_DEPTH = 1 << ANTI_AW;
   localparam int UPC_BITS   = 5;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;

   localparam logic REG_MODULUS = 1'b0;
   localparam logic REG_ROOT    = 1'b1;

   localparam logic [MOD_BITS-1:0] MODULUS_RESET = MOD_BITS'(2);
   localparam logic [MOD_BITS-1:0] ROOT_RESET    = MOD_BITS'(1);

   typedef logic [UPC_BITS-1:0] upc_type;

   typedef enum logic [3:0] {
      OP_NOP, OP_ACCEPT, OP_PCHECK, OP_REM, OP_FIX_N, OP_CHECK_N, OP_TAKE, OP_EMIT,
      OP_BSETUP, OP_P2_A, OP_P2_B, OP_W1, OP_W2, OP_W3, OP_W4, OP_NEXT
   } op_type;

   typedef enum logic [2:0] {
      COND_NONE, COND_ALWAYS, COND_EARLY, COND_REM_MORE, COND_N_SMALL,
      COND_P_LT2, COND_P_GT2, COND_I_DONE
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      upc_type  target;
   } ctrl_word_type;

   typedef struct packed {
      logic fire;
      logic action;
      logic early;
      logic rem_more;
      logic n_small;
      logic p_lt2;
      logic p_gt2;
      logic i_done;
      logic out_free;
   } flags_type;

   localparam upc_type S_IDLE    = 5'd0;
   localparam upc_type S_PCHECK  = 5'd1;
   localparam upc_type S_REM_E   = 5'd2;
   localparam upc_type S_FIX_N   = 5'd3;
   localparam upc_type S_CHECK_N = 5'd4;
   localparam upc_type S_REM_P   = 5'd5;
   localparam upc_type S_ANTI_RD = 5'd6;
   localparam upc_type S_TAKE    = 5'd7;
   localparam upc_type S_EMIT    = 5'd8;
   localparam upc_type S_BSETUP  = 5'd9;
   localparam upc_type S_PSEL    = 5'd10;
   localparam upc_type S_P2_A    = 5'd11;
   localparam upc_type S_P2_B    = 5'd12;
   localparam upc_type S_LOOP    = 5'd13;
   localparam upc_type S_W1      = 5'd14;
   localparam upc_type S_W2      = 5'd15;
   localparam upc_type S_W3      = 5'd16;
   localparam upc_type S_W4      = 5'd17;
   localparam upc_type S_REM_S   = 5'd18;
   localparam upc_type S_NEXT    = 5'd19;

   // microcode ROM; for OP_ACCEPT the target is the build entry
   function automatic ctrl_word_type program_word(upc_type upc);
      ctrl_word_type w;
      unique case (upc)
         S_IDLE:    w = '{OP_ACCEPT,  COND_NONE,     S_BSETUP};
         S_PCHECK:  w = '{OP_PCHECK,  COND_EARLY,    S_EMIT};
         S_REM_E:   w = '{OP_REM,     COND_REM_MORE, S_REM_E};
         S_FIX_N:   w = '{OP_FIX_N,   COND_NONE,     S_IDLE};
         S_CHECK_N: w = '{OP_CHECK_N, COND_N_SMALL,  S_EMIT};
         S_REM_P:   w = '{OP_REM,     COND_REM_MORE, S_REM_P};
         S_ANTI_RD: w = '{OP_NOP,     COND_NONE,     S_IDLE};
         S_TAKE:    w = '{OP_TAKE,    COND_NONE,     S_IDLE};
         S_EMIT:    w = '{OP_EMIT,    COND_ALWAYS,   S_IDLE};
         S_BSETUP:  w = '{OP_BSETUP,  COND_P_LT2,    S_EMIT};
         S_PSEL:    w = '{OP_NOP,     COND_P_GT2,    S_LOOP};
         S_P2_A:    w = '{OP_P2_A,    COND_NONE,     S_IDLE};
         S_P2_B:    w = '{OP_P2_B,    COND_ALWAYS,   S_EMIT};
         S_LOOP:    w = '{OP_NOP,     COND_I_DONE,   S_EMIT};
         S_W1:      w = '{OP_W1,      COND_NONE,     S_IDLE};
         S_W2:      w = '{OP_W2,      COND_NONE,     S_IDLE};
         S_W3:      w = '{OP_W3,      COND_NONE,     S_IDLE};
         S_W4:      w = '{OP_W4,      COND_NONE,     S_IDLE};
         S_REM_S:   w = '{OP_REM,     COND_REM_MORE, S_REM_S};
         S_NEXT:    w = '{OP_NEXT,    COND_ALWAYS,   S_LOOP};
         default:   w = '{OP_NOP,     COND_ALWAYS,   S_IDLE};
      endcase
      return w;
   endfunction

endpackage

// ===== src/pfle_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response words.
// Depends on pfle_pkg.
interface pfle_req_if;
   import pfle_pkg::*;
   logic                       valid;
   logic                       ready;
   logic                       action;
   logic [MOD_BITS-1:0]        base;
   logic signed [EXP_BITS-1:0] exponent;
   modport source (output valid, action, base, exponent, input ready);
   modport sink (input valid, action, base, exponent, output ready);
endinterface

interface pfle_rsp_if;
   import pfle_pkg::*;
   logic                valid;
   logic                ready;
   logic [MOD_BITS-1:0] power_value;
   modport source (output valid, power_value, input ready);
   modport sink (input valid, power_value, output ready);
endinterface

// ===== src/prime_field_log_exp_power.sv =====
`timescale 1ns / 1ps
// Top level of the GF(p) log/antilog power block: APB register file, sequencer, datapath.
// Depends on pfle_pkg, pfle_if, pfle_seq and pfle_datapath.
//
// Write the prime modulus (0x0) and a primitive root (0x4), then send a build word
// (action 0) before any power word (action 1). Every word returns exactly one
// response; a build returns 0. All work runs through one bit-serial remainder unit
// that retires one dividend bit per cycle. A power word runs two reductions from
// acceptance to response: exponent mod p-1, then exponent times log mod p-1. The
// second is skipped when the exponent reduces to 0 or 1, and both when base is 0
// or 1, not below p, or p is below 2. In a build for p above 2, each step of the
// root costs one modular multiply plus four writes to the antilog memory, which
// has a single write port. One word is in flight at a time; the next word is accepted
// in the cycle after the response is loaded, while it waits in the output register.
module prime_field_log_exp_power (
   input  logic                        clock,
   input  logic                        reset,
   pfle_req_if.sink                    req_ch,
   pfle_rsp_if.source                  rsp_ch,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [pfle_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [pfle_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [pfle_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);
   import pfle_pkg::*;

   logic [MOD_BITS-1:0] modulus_ff, modulus_in;
   logic [MOD_BITS-1:0] root_ff, root_in;
   logic                csr_write;
   logic                csr_index;
   ctrl_word_type       ctrl;
   flags_type           flags;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[2];

   always_comb begin
      modulus_in = modulus_ff;
      root_in    = root_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_MODULUS: modulus_in = csr_pwdata[MOD_BITS-1:0];
            REG_ROOT:    root_in    = csr_pwdata[MOD_BITS-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_MODULUS: csr_prdata = CSR_DW'(modulus_ff);
         REG_ROOT:    csr_prdata = CSR_DW'(root_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RESET;
         root_ff    <= ROOT_RESET;
      end else begin
         modulus_ff <= modulus_in;
         root_ff    <= root_in;
      end
   end

   pfle_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   pfle_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .ctrl    (ctrl),
      .modulus (modulus_ff),
      .root    (root_ff),
      .flags   (flags)
   );

endmodule

// ===== src/pfle_rem.sv =====
`timescale 1ns / 1ps
// Bit-serial remainder unit: one dividend bit per cycle, restoring compare/subtract.
// Advances only while step is high. Depends on pfle_pkg.
module pfle_rem (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic                          step,
   input  logic [pfle_pkg::DVD_BITS-1:0] dividend,
   input  logic [pfle_pkg::MOD_BITS-1:0] divisor,
   output logic [pfle_pkg::MOD_BITS-1:0] remainder,
   output logic [pfle_pkg::MOD_BITS-1:0] divisor_q,
   output logic                          more
);
   import pfle_pkg::*;

   logic [DVD_BITS-1:0] dvd_ff, dvd_in;
   logic [MOD_BITS-1:0] rem_ff, rem_in;
   logic [MOD_BITS-1:0] dsr_ff, dsr_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [MOD_BITS:0]   shifted;
   logic [MOD_BITS:0]   diff;

   assign shifted = {rem_ff, dvd_ff[DVD_BITS-1]};
   assign diff    = shifted - {1'b0, dsr_ff};

   always_comb begin
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      if (load) begin
         dvd_in = dividend;
         dsr_in = divisor;
         rem_in = '0;
         cnt_in = '0;
      end else if (step) begin
         dvd_in = dvd_ff << 1;
         rem_in = (shifted >= {1'b0, dsr_ff}) ? diff[MOD_BITS-1:0] : shifted[MOD_BITS-1:0];
         cnt_in = cnt_ff + CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign remainder = rem_ff;
   assign divisor_q = dsr_ff;
   assign more      = (cnt_ff != CNT_BITS'(DVD_BITS - 1));

endmodule

// ===== src/pfle_seq.sv =====
`timescale 1ns / 1ps
// Microcode sequencer: step counter, program ROM lookup and conditional jumps.
// Depends on pfle_pkg.
module pfle_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  pfle_pkg::flags_type     flags,
   output pfle_pkg::ctrl_word_type ctrl
);
   import pfle_pkg::*;

   upc_type upc_ff, upc_in;
   logic    cond_true;

   always_comb begin
      ctrl = program_word(upc_ff);
   end

   always_comb begin
      unique case (ctrl.cond)
         COND_NONE:     cond_true = 1'b0;
         COND_ALWAYS:   cond_true = 1'b1;
         COND_EARLY:    cond_true = flags.early;
         COND_REM_MORE: cond_true = flags.rem_more;
         COND_N_SMALL:  cond_true = flags.n_small;
         COND_P_LT2:    cond_true = flags.p_lt2;
         COND_P_GT2:    cond_true = flags.p_gt2;
         COND_I_DONE:   cond_true = flags.i_done;
      endcase
   end

   always_comb begin
      unique case (ctrl.op)
         OP_ACCEPT: begin
            if (flags.fire) begin
               upc_in = flags.action ? (upc_ff + UPC_BITS'(1)) : ctrl.target;
            end else begin
               upc_in = upc_ff;
            end
         end
         OP_EMIT: upc_in = flags.out_free ? ctrl.target : upc_ff;
         default: upc_in = cond_true ? ctrl.target : (upc_ff + UPC_BITS'(1));
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= S_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

// ===== src/pfle_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: operand registers, log and antilog memories, remainder unit, result register.
// Depends on pfle_pkg, pfle_if and pfle_rem.
module pfle_datapath (
   input  logic                          clock,
   input  logic                          reset,
   pfle_req_if.sink                      req,
   pfle_rsp_if.source                    rsp,
   input  pfle_pkg::ctrl_word_type       ctrl,
   input  logic [pfle_pkg::MOD_BITS-1:0] modulus,
   input  logic [pfle_pkg::MOD_BITS-1:0] root,
   output pfle_pkg::flags_type           flags
);
   import pfle_pkg::*;

   logic [MOD_BITS-1:0] x_ff, x_in;
   logic [EXP_BITS-1:0] e_ff, e_in;
   logic                neg_ff, neg_in;
   logic [MOD_BITS-1:0] n_ff, n_in;
   logic [MOD_BITS-1:0] res_ff, res_in;
   logic [MOD_BITS-1:0] s_ff, s_in;
   logic [MOD_BITS-1:0] i_ff, i_in;
   logic [MOD_BITS-1:0] half_ff, half_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [MOD_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic [MOD_BITS-1:0] log_rd_ff;
   logic [MOD_BITS-1:0] anti_rd_ff;

   logic [MOD_BITS-1:0] log_mem [LOG_DEPTH];
   logic [MOD_BITS-1:0] anti_mem [ANTI_DEPTH];

   logic                req_fire;
   logic                out_free;
   logic                rsp_load;
   logic [EXP_BITS-1:0] mag;
   logic [MOD_BITS-1:0] m;
   logic [MOD_BITS-1:0] p_minus_s;
   logic [ANTI_AW-1:0]  idx_i;
   logic [ANTI_AW-1:0]  idx_wrap;

   logic                rem_load;
   logic                rem_step;
   logic [DVD_BITS-1:0] rem_dividend;
   logic [MOD_BITS-1:0] rem_divisor;
   logic [MOD_BITS-1:0] rem;
   logic [MOD_BITS-1:0] rem_div_q;
   logic                rem_more;

   logic                log_we;
   logic [MOD_BITS-1:0] log_waddr;
   logic [MOD_BITS-1:0] log_wdata;
   logic                anti_we;
   logic [ANTI_AW-1:0]  anti_waddr;
   logic [MOD_BITS-1:0] anti_wdata;

   pfle_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .load      (rem_load),
      .step      (rem_step),
      .dividend  (rem_dividend),
      .divisor   (rem_divisor),
      .remainder (rem),
      .divisor_q (rem_div_q),
      .more      (rem_more)
   );

   assign req.ready = (ctrl.op == OP_ACCEPT);
   assign req_fire  = req.valid && req.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign rsp_load  = (ctrl.op == OP_EMIT) && out_free;

   assign mag       = '0 - e_ff;
   assign m         = modulus - MOD_BITS'(1);
   assign p_minus_s = modulus - s_ff;
   assign idx_i     = ANTI_AW'(i_ff);
   assign idx_wrap  = idx_i + ANTI_AW'(modulus) - ANTI_AW'(1);

   always_comb begin
      flags.fire     = req_fire;
      flags.action   = req.action;
      flags.early    = (x_ff == '0) || (x_ff == MOD_BITS'(1)) || (modulus < MOD_BITS'(2))
                       || (x_ff >= modulus);
      flags.rem_more = rem_more;
      flags.n_small  = (n_ff <= MOD_BITS'(1));
      flags.p_lt2    = (modulus < MOD_BITS'(2));
      flags.p_gt2    = (modulus > MOD_BITS'(2));
      flags.i_done   = (i_ff >= half_ff);
      flags.out_free = out_free;
   end

   always_comb begin
      x_in         = x_ff;
      e_in         = e_ff;
      neg_in       = neg_ff;
      n_in         = n_ff;
      res_in       = res_ff;
      s_in         = s_ff;
      i_in         = i_ff;
      half_in      = half_ff;
      rem_load     = 1'b0;
      rem_step     = 1'b0;
      rem_dividend = '0;
      rem_divisor  = rem_div_q;
      log_we       = 1'b0;
      log_waddr    = s_ff;
      log_wdata    = i_ff;
      anti_we      = 1'b0;
      anti_waddr   = idx_i;
      anti_wdata   = s_ff;
      unique case (ctrl.op)
         OP_NOP: ;
         OP_ACCEPT: begin
            if (req_fire) begin
               x_in = req.base;
               e_in = req.exponent;
            end
         end
         OP_PCHECK: begin
            res_in       = (x_ff == MOD_BITS'(1)) ? MOD_BITS'(1) : '0;
            neg_in       = e_ff[EXP_BITS-1];
            rem_load     = 1'b1;
            rem_dividend = DVD_BITS'(e_ff[EXP_BITS-1] ? mag : e_ff);
            rem_divisor  = m;
         end
         OP_REM: rem_step = 1'b1;
         OP_FIX_N: n_in = (neg_ff && (rem != '0)) ? (rem_div_q - rem) : rem;
         OP_CHECK_N: begin
            res_in       = (n_ff == '0) ? MOD_BITS'(1) : x_ff;
            rem_load     = 1'b1;
            rem_dividend = DVD_BITS'(PROD_BITS'(n_ff) * PROD_BITS'(log_rd_ff));
         end
         OP_TAKE: res_in = anti_rd_ff;
         OP_EMIT: ;
         OP_BSETUP: begin
            res_in  = '0;
            s_in    = MOD_BITS'(1);
            i_in    = '0;
            half_in = m >> 1;
         end
         OP_P2_A: begin
            log_we     = 1'b1;
            log_waddr  = MOD_BITS'(1);
            log_wdata  = '0;
            anti_we    = 1'b1;
            anti_waddr = '0;
            anti_wdata = MOD_BITS'(1);
         end
         OP_P2_B: begin
            anti_we    = 1'b1;
            anti_waddr = ANTI_AW'(1);
            anti_wdata = MOD_BITS'(1);
         end
         OP_W1: begin
            log_we  = 1'b1;
            anti_we = 1'b1;
         end
         OP_W2: begin
            log_we     = 1'b1;
            log_waddr  = p_minus_s;
            log_wdata  = i_ff + half_ff;
            anti_we    = 1'b1;
            anti_waddr = idx_i + ANTI_AW'(half_ff);
            anti_wdata = p_minus_s;
         end
         OP_W3: begin
            anti_we      = 1'b1;
            anti_waddr   = idx_wrap;
            rem_load     = 1'b1;
            rem_dividend = DVD_BITS'(PROD_BITS'(s_ff) * PROD_BITS'(root));
            rem_divisor  = modulus;
         end
         OP_W4: begin
            anti_we    = 1'b1;
            anti_waddr = idx_wrap + ANTI_AW'(half_ff);
            anti_wdata = p_minus_s;
         end
         OP_NEXT: begin
            s_in = rem;
            i_in = i_ff + MOD_BITS'(1);
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = res_ff;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      e_ff         <= e_in;
      neg_ff       <= neg_in;
      n_ff         <= n_in;
      res_ff       <= res_in;
      s_ff         <= s_in;
      i_ff         <= i_in;
      half_ff      <= half_in;
      rsp_value_ff <= rsp_value_in;
   end

   always_ff @(posedge clock) begin
      if (log_we) begin
         log_mem[log_waddr] <= log_wdata;
      end
      log_rd_ff <= log_mem[x_ff];
   end

   always_ff @(posedge clock) begin
      if (anti_we) begin
         anti_mem[anti_waddr] <= anti_wdata;
      end
      anti_rd_ff <= anti_mem[ANTI_AW'(rem)];
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.power_value = rsp_value_ff;

   a_rem_reduced: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_FIX_N) |-> (rem < rem_div_q))
      else $error("exponent remainder not below p-1");

   a_n_reduced: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_CHECK_N) |-> (n_ff < rem_div_q))
      else $error("reduced exponent not below p-1");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl.op == OP_EMIT))
      else $error("response raised outside emit step");

endmodule
